// ===== src/lsch_pkg.sv =====
package lsch_pkg;

  localparam int SlotCount    = 16;
  localparam int TicketBits   = 16;
  localparam int SlotIdxBits  = $clog2(SlotCount);
  localparam int TotalBits    = TicketBits + SlotIdxBits;
  localparam int RndBits      = 31;
  localparam int OutTotalBits = 20;

  localparam logic [TicketBits-1:0]   TicketMax   = '1;
  localparam logic [OutTotalBits-1:0] OutTotalMax = '1;

  localparam logic [2:0] OpAssign  = 3'd0;
  localparam logic [2:0] OpReady   = 3'd1;
  localparam logic [2:0] OpMove    = 3'd2;
  localparam logic [2:0] OpRelease = 3'd3;
  localparam logic [2:0] OpDraw    = 3'd4;

  typedef logic [TicketBits-1:0]  ticket_t;
  typedef logic [TotalBits-1:0]   total_t;
  typedef logic [SlotIdxBits-1:0] slot_idx_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [3:0]         slot;
    logic [3:0]         other_slot;
    logic [15:0]        ticket_count;
    logic               is_ready;
    logic [RndBits-1:0] random_value;
  } req_t;

  typedef struct packed {
    logic                    found;
    logic [3:0]              winner_slot;
    logic [15:0]             moved;
    logic [OutTotalBits-1:0] total_ready;
  } res_t;

  function automatic logic [OutTotalBits-1:0] sat_total(input total_t t);
    if (64'(t) > 64'(OutTotalMax)) begin
      return OutTotalMax;
    end
    return OutTotalBits'(t);
  endfunction

endpackage

// ===== src/lsch_ram.sv =====
module lsch_ram #(
  parameter int Depth = 16,
  parameter int Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/lsch_mod.sv =====
module lsch_mod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lsch_pkg::RndBits-1:0] dividend_i,
  input  lsch_pkg::total_t             divisor_i,
  output logic                         done_o,
  output lsch_pkg::total_t             rem_o
);

  localparam int CntBits = $clog2(lsch_pkg::RndBits);

  logic                         busy_q, done_q;
  logic [CntBits-1:0]           cnt_q;
  logic [lsch_pkg::RndBits-1:0] dvd_q;
  lsch_pkg::total_t             div_q, rem_q;
  logic [lsch_pkg::TotalBits:0] trial, div_ext;
  logic                         ge;

  assign trial   = {rem_q, dvd_q[lsch_pkg::RndBits-1]};
  assign div_ext = {1'b0, div_q};
  assign ge      = trial >= div_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(lsch_pkg::RndBits - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring remainder, one dividend bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= ge ? lsch_pkg::TotalBits'(trial - div_ext) : trial[lsch_pkg::TotalBits-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/lottery_scheduler.sv =====
// Request accepted to result valid: a no-op goes straight to StResult; assign, set ready
// and release pass through StRdSrc, a transfer through StRdSrc, StRdDst and StWrSrc, a draw
// through the serial remainder, then one ticket RAM read per slot walked, up to 16.
// One request in flight; the next is taken in the cycle after the result register is loaded.
// Reset clears ready and in-use marks and the ready total; the ticket RAM is not cleared,
// a slot's entry is only used once it has been assigned.
module lottery_scheduler (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lsch_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output lsch_pkg::res_t out_res_o
);

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StRdSrc  = 7'b0000010,
    StRdDst  = 7'b0000100,
    StWrSrc  = 7'b0001000,
    StMod    = 7'b0010000,
    StWalk   = 7'b0100000,
    StResult = 7'b1000000
  } state_e;

  function automatic lsch_pkg::ticket_t sat_ticket(input logic [15:0] v);
    if (33'(v) > 33'(lsch_pkg::TicketMax)) begin
      return lsch_pkg::TicketMax;
    end
    return lsch_pkg::TicketBits'(v);
  endfunction

  state_e                           state_q, state_d;
  lsch_pkg::req_t                   req_q, req_d;
  lsch_pkg::total_t                 total_q, total_d;
  logic [lsch_pkg::SlotCount-1:0]   ready_q, ready_d, in_use_q, in_use_d;
  logic                             found_q, found_d;
  lsch_pkg::slot_idx_t              win_q, win_d, idx_q, idx_d;
  lsch_pkg::ticket_t                m_q, m_d, src_q, src_d;
  lsch_pkg::total_t                 acc_q, acc_d, target_q, target_d;
  lsch_pkg::res_t                   res_q, res_d;
  logic                             out_valid_q, out_valid_d;

  logic                             ram_we;
  lsch_pkg::slot_idx_t              ram_waddr, ram_raddr;
  lsch_pkg::ticket_t                ram_wdata, ram_rdata;

  logic                             mod_start, mod_done;
  lsch_pkg::total_t                 mod_rem;

  logic                             in_accept, out_free;
  lsch_pkg::slot_idx_t              in_s_idx, in_d_idx, s_idx, d_idx;
  logic                             in_s_ok, in_d_ok, in_live_s, in_live_d;
  lsch_pkg::ticket_t                req_sat, room, mv;
  logic                             walk_live, walk_last;
  lsch_pkg::total_t                 acc_sum;

  lsch_ram #(
    .Depth(lsch_pkg::SlotCount),
    .Width(lsch_pkg::TicketBits)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  lsch_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mod_start),
    .dividend_i(in_req_i.random_value),
    .divisor_i (total_q),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  assign in_s_idx  = lsch_pkg::SlotIdxBits'(in_req_i.slot);
  assign in_d_idx  = lsch_pkg::SlotIdxBits'(in_req_i.other_slot);
  assign in_s_ok   = 32'(in_req_i.slot) < 32'(lsch_pkg::SlotCount);
  assign in_d_ok   = 32'(in_req_i.other_slot) < 32'(lsch_pkg::SlotCount);
  assign in_live_s = in_s_ok && in_use_q[in_s_idx];
  assign in_live_d = in_d_ok && in_use_q[in_d_idx];
  assign s_idx     = lsch_pkg::SlotIdxBits'(req_q.slot);
  assign d_idx     = lsch_pkg::SlotIdxBits'(req_q.other_slot);

  // transfer: rdata holds the destination count in StRdDst
  always_comb begin
    req_sat = sat_ticket(req_q.ticket_count);
    room    = lsch_pkg::TicketMax - ram_rdata;
    mv      = req_sat;
    if (src_q < mv) begin
      mv = src_q;
    end
    if (room < mv) begin
      mv = room;
    end
  end

  assign walk_live = ready_q[idx_q] && in_use_q[idx_q];
  assign walk_last = idx_q == lsch_pkg::SlotIdxBits'(lsch_pkg::SlotCount - 1);
  assign acc_sum   = acc_q + (walk_live ? lsch_pkg::TotalBits'(ram_rdata) : '0);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    total_d     = total_q;
    ready_d     = ready_q;
    in_use_d    = in_use_q;
    found_d     = found_q;
    win_d       = win_q;
    idx_d       = idx_q;
    m_d         = m_q;
    src_d       = src_q;
    acc_d       = acc_q;
    target_d    = target_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = s_idx;
    ram_wdata   = sat_ticket(req_q.ticket_count);
    ram_raddr   = '0;
    mod_start   = 1'b0;

    case (state_q)
      StIdle: begin
        ram_raddr = in_s_idx;
        if (in_accept) begin
          req_d   = in_req_i;
          found_d = 1'b0;
          win_d   = '0;
          m_d     = '0;
          state_d = StResult;
          case (in_req_i.operation)
            lsch_pkg::OpAssign: begin
              if (in_s_ok) state_d = StRdSrc;
            end
            lsch_pkg::OpReady: begin
              if (in_live_s && (ready_q[in_s_idx] != in_req_i.is_ready)) state_d = StRdSrc;
            end
            lsch_pkg::OpMove: begin
              if (in_live_s && in_live_d && (in_req_i.slot != in_req_i.other_slot)) begin
                state_d = StRdSrc;
              end
            end
            lsch_pkg::OpRelease: begin
              if (in_live_s) state_d = StRdSrc;
            end
            lsch_pkg::OpDraw: begin
              if (total_q != '0) begin
                mod_start = 1'b1;
                state_d   = StMod;
              end
            end
            default: ;
          endcase
        end
      end
      StRdSrc: begin
        ram_raddr = d_idx;
        state_d   = StResult;
        case (req_q.operation)
          lsch_pkg::OpAssign: begin
            if (in_use_q[s_idx] && ready_q[s_idx]) begin
              total_d = total_q - lsch_pkg::TotalBits'(ram_rdata);
            end
            ram_we          = 1'b1;
            ready_d[s_idx]  = 1'b0;
            in_use_d[s_idx] = 1'b1;
          end
          lsch_pkg::OpReady: begin
            if (req_q.is_ready) begin
              total_d = total_q + lsch_pkg::TotalBits'(ram_rdata);
            end else begin
              total_d = total_q - lsch_pkg::TotalBits'(ram_rdata);
            end
            ready_d[s_idx] = req_q.is_ready;
          end
          lsch_pkg::OpMove: begin
            src_d   = ram_rdata;
            state_d = StRdDst;
          end
          lsch_pkg::OpRelease: begin
            if (ready_q[s_idx]) begin
              total_d = total_q - lsch_pkg::TotalBits'(ram_rdata);
            end
            ready_d[s_idx]  = 1'b0;
            in_use_d[s_idx] = 1'b0;
          end
          default: ;
        endcase
      end
      StRdDst: begin
        ram_we    = 1'b1;
        ram_waddr = d_idx;
        ram_wdata = ram_rdata + mv;
        m_d       = mv;
        if (ready_q[s_idx] && !ready_q[d_idx]) begin
          total_d = total_q - lsch_pkg::TotalBits'(mv);
        end else if (ready_q[d_idx] && !ready_q[s_idx]) begin
          total_d = total_q + lsch_pkg::TotalBits'(mv);
        end
        state_d = StWrSrc;
      end
      StWrSrc: begin
        ram_we    = 1'b1;
        ram_wdata = src_q - m_q;
        state_d   = StResult;
      end
      StMod: begin
        if (mod_done) begin
          target_d = mod_rem + 1'b1;
          acc_d    = '0;
          idx_d    = '0;
          state_d  = StWalk;
        end
      end
      StWalk: begin
        ram_raddr = idx_q + 1'b1;
        acc_d     = acc_sum;
        if (walk_live && (target_q <= acc_sum)) begin
          found_d = 1'b1;
          win_d   = idx_q;
          state_d = StResult;
        end else if (walk_last) begin
          state_d = StResult;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StResult: begin
        if (out_free) begin
          res_d.found       = found_q;
          res_d.winner_slot = 4'(win_q);
          res_d.moved       = 16'(m_q);
          res_d.total_ready = lsch_pkg::sat_total(total_q);
          out_valid_d       = 1'b1;
          state_d           = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      total_q     <= '0;
      ready_q     <= '0;
      in_use_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      ready_q     <= ready_d;
      in_use_q    <= in_use_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    found_q  <= found_d;
    win_q    <= win_d;
    idx_q    <= idx_d;
    m_q      <= m_d;
    src_q    <= src_d;
    acc_q    <= acc_d;
    target_q <= target_d;
    res_q    <= res_d;
  end

endmodule

// ===== src/lsch_chk.sv =====
module lsch_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input lsch_pkg::req_t in_req_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input lsch_pkg::res_t out_res_o
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("result changed while stalled");

  // one request in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

  a_no_win_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.found |-> out_res_o.winner_slot == 4'd0)
    else $error("winner slot without a winner");

  a_draw_moves_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.found |-> out_res_o.moved == 16'd0)
    else $error("draw result reports moved tickets");

endmodule

bind lottery_scheduler lsch_chk u_lsch_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_req_i   (in_req_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_res_o  (out_res_o)
);

// ===== tb/sv/lsch_checker.sv =====
module lsch_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  lsch_pkg::req_t in_req_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  lsch_pkg::res_t out_res_i,
  output int             errors_o,
  output int             pending_o
);

  localparam int ReportLimit = 10;

  lsch_pkg::ticket_t              tickets [lsch_pkg::SlotCount];
  logic [lsch_pkg::SlotCount-1:0] ready_marks;
  logic [lsch_pkg::SlotCount-1:0] in_use;
  lsch_pkg::total_t               ready_sum;
  lsch_pkg::res_t                 lottery_results_q [$];
  int                             mismatches;

  function automatic lsch_pkg::res_t lottery_step(input lsch_pkg::req_t r);
    lsch_pkg::res_t      o;
    lsch_pkg::ticket_t   m;
    lsch_pkg::ticket_t   room;
    lsch_pkg::total_t    target;
    lsch_pkg::total_t    acc;
    lsch_pkg::slot_idx_t s;
    lsch_pkg::slot_idx_t d;
    o = '0;
    s = lsch_pkg::SlotIdxBits'(r.slot);
    d = lsch_pkg::SlotIdxBits'(r.other_slot);
    case (r.operation)
      lsch_pkg::OpAssign: begin
        if (in_use[s] && ready_marks[s]) begin
          ready_sum -= lsch_pkg::TotalBits'(tickets[s]);
        end
        tickets[s]     = lsch_pkg::TicketBits'(r.ticket_count);
        ready_marks[s] = 1'b0;
        in_use[s]      = 1'b1;
      end
      lsch_pkg::OpReady: begin
        if (in_use[s] && ready_marks[s] != r.is_ready) begin
          if (r.is_ready) begin
            ready_sum += lsch_pkg::TotalBits'(tickets[s]);
          end else begin
            ready_sum -= lsch_pkg::TotalBits'(tickets[s]);
          end
          ready_marks[s] = r.is_ready;
        end
      end
      lsch_pkg::OpMove: begin
        if (in_use[s] && in_use[d] && s != d) begin
          m    = lsch_pkg::TicketBits'(r.ticket_count);
          room = lsch_pkg::TicketMax - tickets[d];
          if (tickets[s] < m) begin
            m = tickets[s];
          end
          if (room < m) begin
            m = room;
          end
          tickets[s] -= m;
          tickets[d] += m;
          if (ready_marks[s] && !ready_marks[d]) begin
            ready_sum -= lsch_pkg::TotalBits'(m);
          end else if (ready_marks[d] && !ready_marks[s]) begin
            ready_sum += lsch_pkg::TotalBits'(m);
          end
          o.moved = 16'(m);
        end
      end
      lsch_pkg::OpRelease: begin
        if (in_use[s]) begin
          if (ready_marks[s]) begin
            ready_sum -= lsch_pkg::TotalBits'(tickets[s]);
          end
          tickets[s]     = '0;
          ready_marks[s] = 1'b0;
          in_use[s]      = 1'b0;
        end
      end
      lsch_pkg::OpDraw: begin
        if (ready_sum != '0) begin
          target = lsch_pkg::TotalBits'(r.random_value % ready_sum) + lsch_pkg::TotalBits'(1);
          acc    = '0;
          for (int i = 0; i < lsch_pkg::SlotCount; i++) begin
            if (!o.found && in_use[i] && ready_marks[i]) begin
              acc += lsch_pkg::TotalBits'(tickets[i]);
              if (target <= acc) begin
                o.found       = 1'b1;
                o.winner_slot = 4'(i);
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (64'(ready_sum) > 64'(lsch_pkg::OutTotalMax)) begin
      o.total_ready = lsch_pkg::OutTotalMax;
    end else begin
      o.total_ready = lsch_pkg::OutTotalBits'(ready_sum);
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lsch_pkg::res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < lsch_pkg::SlotCount; i++) begin
        tickets[i] = '0;
      end
      ready_marks = '0;
      in_use      = '0;
      ready_sum   = '0;
      lottery_results_q.delete();
      mismatches  = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (lottery_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("unexpected result: found=%0d slot=%0d moved=%0d total=%0d",
                     out_res_i.found, out_res_i.winner_slot, out_res_i.moved,
                     out_res_i.total_ready);
          end
        end else begin
          want = lottery_results_q.pop_front();
          if (want.found !== out_res_i.found || want.winner_slot !== out_res_i.winner_slot ||
              want.moved !== out_res_i.moved || want.total_ready !== out_res_i.total_ready) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("mismatch: want found=%0d slot=%0d moved=%0d total=%0d",
                       want.found, want.winner_slot, want.moved, want.total_ready);
              $display("          got  found=%0d slot=%0d moved=%0d total=%0d",
                       out_res_i.found, out_res_i.winner_slot, out_res_i.moved,
                       out_res_i.total_ready);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        lottery_results_q.push_back(lottery_step(in_req_i));
      end
      errors_o  <= mismatches;
      pending_o <= lottery_results_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_lottery_scheduler.sv =====
module tb_lottery_scheduler;

  localparam logic [2:0] OpSpareLo   = 3'd5;
  localparam logic [2:0] OpSpareHi   = 3'd7;
  localparam int         HoldCycles  = 300;
  localparam int         DrainCycles = 60;
  localparam int         CycleLimit  = 200000;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_stall_o;
  lsch_pkg::req_t in_req_i    = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  lsch_pkg::res_t out_res_o;

  int errors;
  int pending;
  int gap_pct   = 0;
  int stall_pct = 0;
  int hold_trig = 0;
  int hold_seen = 0;
  int hold_left = 0;
  logic [lsch_pkg::SlotCount-1:0] claimed = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lottery_scheduler i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

  lsch_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_i  (out_res_o),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // result side: random stall, or a long hold-off when triggered
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_seen   <= 0;
      hold_left   <= 0;
    end else if (hold_seen != hold_trig) begin
      hold_seen   <= hold_trig;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb_lottery_scheduler failed");
    $finish;
  end

  function automatic lsch_pkg::req_t mk(input logic [2:0] op, input logic [3:0] s,
                                        input logic [3:0] d, input logic [15:0] t,
                                        input logic rdy,
                                        input logic [lsch_pkg::RndBits-1:0] rv);
    lsch_pkg::req_t r;
    r.operation    = op;
    r.slot         = s;
    r.other_slot   = d;
    r.ticket_count = t;
    r.is_ready     = rdy;
    r.random_value = rv;
    return r;
  endfunction

  task automatic send_req(input lsch_pkg::req_t r);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic pick_slot(output logic [3:0] s);
    s = 4'($urandom_range(lsch_pkg::SlotCount - 1));
    if (claimed != '0 && $urandom_range(4) != 0) begin
      while (!claimed[s]) s = 4'($urandom_range(lsch_pkg::SlotCount - 1));
    end
  endtask

  task automatic random_burst(input int n);
    lsch_pkg::req_t r;
    int             sel;
    repeat (n) begin
      r.is_ready = ($urandom_range(3) != 0);
      pick_slot(r.slot);
      pick_slot(r.other_slot);
      case ($urandom_range(9))
        0:       r.ticket_count = '0;
        1:       r.ticket_count = lsch_pkg::TicketMax;
        2, 3, 4: r.ticket_count = 16'($urandom_range(255));
        default: r.ticket_count = 16'($urandom);
      endcase
      case ($urandom_range(5))
        0:       r.random_value = lsch_pkg::RndBits'($urandom_range(3));
        1:       r.random_value = {lsch_pkg::RndBits{1'b1}} -
                                  lsch_pkg::RndBits'($urandom_range(3));
        default: r.random_value = lsch_pkg::RndBits'($urandom);
      endcase
      sel = $urandom_range(99);
      if (sel < 18) begin
        r.operation = lsch_pkg::OpAssign;
        claimed[r.slot] = 1'b1;
      end else if (sel < 40) begin
        r.operation = lsch_pkg::OpReady;
      end else if (sel < 60) begin
        r.operation = lsch_pkg::OpMove;
      end else if (sel < 67) begin
        r.operation = lsch_pkg::OpRelease;
        claimed[r.slot] = 1'b0;
      end else if (sel < 93) begin
        r.operation = lsch_pkg::OpDraw;
      end else begin
        r.operation = 3'($urandom_range(int'(OpSpareHi), int'(OpSpareLo)));
      end
      send_req(r);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, operations on unused slots, then assigns, ready marks and draws
    send_req(mk(lsch_pkg::OpDraw,    4'd0,  4'd0,  16'd0,   1'b0, '1));
    send_req(mk(lsch_pkg::OpReady,   4'd3,  4'd0,  16'd0,   1'b1, '0));
    send_req(mk(lsch_pkg::OpMove,    4'd3,  4'd4,  16'd100, 1'b0, '0));
    send_req(mk(lsch_pkg::OpRelease, 4'd9,  4'd0,  16'd0,   1'b0, '0));
    send_req(mk(lsch_pkg::OpAssign,  4'd0,  4'd0,  lsch_pkg::TicketMax, 1'b0, '0));
    send_req(mk(lsch_pkg::OpAssign,  4'd15, 4'd0,  16'd0,   1'b0, '0));
    send_req(mk(lsch_pkg::OpAssign,  4'd5,  4'd0,  16'd100, 1'b0, '0));
    send_req(mk(lsch_pkg::OpReady,   4'd0,  4'd0,  16'd0,   1'b1, '0));
    send_req(mk(lsch_pkg::OpReady,   4'd0,  4'd0,  16'd0,   1'b1, '0));
    send_req(mk(lsch_pkg::OpReady,   4'd5,  4'd0,  16'd0,   1'b1, '0));
    send_req(mk(lsch_pkg::OpDraw,    4'd0,  4'd0,  16'd0,   1'b0, '0));
    send_req(mk(lsch_pkg::OpDraw,    4'd0,  4'd0,  16'd0,   1'b0, '1));
    send_req(mk(lsch_pkg::OpDraw,    4'd0,  4'd0,  16'd0,   1'b0,
                lsch_pkg::RndBits'(65535)));
    // headroom limit, ready to idle, same slot, source limit, spare operation codes
    send_req(mk(lsch_pkg::OpMove,    4'd0,  4'd5,  lsch_pkg::TicketMax, 1'b0, '0));
    send_req(mk(lsch_pkg::OpMove,    4'd5,  4'd15, 16'd50,  1'b0, '0));
    send_req(mk(lsch_pkg::OpMove,    4'd15, 4'd15, 16'd10,  1'b0, '0));
    send_req(mk(lsch_pkg::OpMove,    4'd15, 4'd0,  lsch_pkg::TicketMax, 1'b1, '0));
    send_req(mk(OpSpareLo,           4'd0,  4'd0,  16'd0,   1'b0, '0));
    send_req(mk(OpSpareLo + 3'd1,    4'd0,  4'd0,  16'd0,   1'b0, '0));
    send_req(mk(OpSpareHi,           4'd0,  4'd0,  16'd0,   1'b0, '0));
    // reassign a ready slot, then empty draw, a draw with one ready slot, releases
    send_req(mk(lsch_pkg::OpAssign,  4'd0,  4'd0,  16'd7,   1'b0, '0));
    send_req(mk(lsch_pkg::OpReady,   4'd5,  4'd0,  16'd0,   1'b0, '0));
    send_req(mk(lsch_pkg::OpDraw,    4'd0,  4'd0,  16'd0,   1'b0,
                lsch_pkg::RndBits'(12345)));
    send_req(mk(lsch_pkg::OpReady,   4'd0,  4'd0,  16'd0,   1'b1, '0));
    send_req(mk(lsch_pkg::OpDraw,    4'd0,  4'd0,  16'd0,   1'b0, lsch_pkg::RndBits'(3)));
    send_req(mk(lsch_pkg::OpRelease, 4'd0,  4'd0,  16'd0,   1'b0, '0));
    send_req(mk(lsch_pkg::OpRelease, 4'd5,  4'd0,  16'd0,   1'b0, '0));
    send_req(mk(lsch_pkg::OpRelease, 4'd15, 4'd0,  16'd0,   1'b0, '0));
    wait_drained();

    // back-to-back, with one long result hold-off in the middle
    random_burst(60);
    hold_trig <= hold_trig + 1;
    random_burst(20);
    random_burst(60);
    wait_drained();

    gap_pct = 60;
    random_burst(140);
    wait_drained();

    gap_pct = 0;
    stall_pct <= 60;
    random_burst(140);
    wait_drained();

    gap_pct = 9;
    stall_pct <= 9;
    random_burst(130);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("tb_lottery_scheduler passed");
    end else begin
      $display("tb_lottery_scheduler failed");
    end
    $finish;
  end

endmodule

// ===== lottery_scheduler.f =====
src/lsch_pkg.sv
src/lsch_ram.sv
src/lsch_mod.sv
src/lottery_scheduler.sv
src/lsch_chk.sv
tb/sv/lsch_checker.sv
tb/sv/tb_lottery_scheduler.sv
